// File: rtl/hms_pkg.sv
package hms_pkg;

    localparam int MAX_MOMENTS = 128;
    localparam int GRID_SIZE   = 256;
    localparam int FRAC_BITS   = 32;
    localparam int COEF_BITS   = 28;
    localparam int PROD_SHIFT  = 32;
    localparam int MW          = 48;
    localparam int CIW         = $clog2(MAX_MOMENTS + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_MOMENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = 2'd1;

    localparam logic [6:0]  HM_RESET       = 7'd100;
    localparam logic [31:0] STEP_RESET     = 32'd429497;
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic [25:0] DT_CAP         = 26'd42949673;
    localparam logic [63:0] INJECT_IM      = ((64'd32 << FRAC_BITS) + 64'd5) / 64'd10;

    typedef logic [31:0] t_coef_tab [0:MAX_MOMENTS];

    function automatic logic [31:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v  = v_in;
        r  = '0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 64'd0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r[31:0];
    endfunction

    function automatic t_coef_tab f_coef_tab();
        t_coef_tab t;
        for (int k = 0; k <= MAX_MOMENTS; k++) begin
            t[k] = f_isqrt(64'(k) << (2 * COEF_BITS - 1));
        end
        return t;
    endfunction

    localparam t_coef_tab COEF_TAB = f_coef_tab();

    typedef struct packed {
        logic               start;
        logic               clr;
        logic               s28;
        logic signed [63:0] a;
        logic [63:0]        b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
        logic [127:0]       acc;
    } t_mul_rsp;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b0_0000_0001,
        ST_ISSUE = 9'b0_0000_0010,
        ST_WAIT  = 9'b0_0000_0100,
        ST_DIV   = 9'b0_0000_1000,
        ST_FIN   = 9'b0_0001_0000,
        ST_OUT1  = 9'b0_0010_0000,
        ST_DTSEL = 9'b0_0100_0000,
        ST_FIN2  = 9'b0_1000_0000,
        ST_OUT2  = 9'b1_0000_0000
    } t_state;

    typedef enum logic [4:0] {
        OP_W, OP_MM2, OP_MM3, OP_MM6, OP_MH2, OP_MH3, OP_MH6,
        OP_T1, OP_T2, OP_T3, OP_T4, OP_S1, OP_S2, OP_S3, OP_S4,
        OP_N1, OP_N2, OP_Q1, OP_Q2, OP_D1, OP_D2
    } t_op;

endpackage

// File: rtl/hms_in_if.sv
interface hms_in_if import hms_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [MW-1:0] moment_re;
    logic signed [MW-1:0] moment_im;
    logic [7:0]           point_x;
    logic [7:0]           point_y;
    logic                 sweep_end;

    modport source (output valid, moment_re, moment_im, point_x, point_y, sweep_end,
                    input ready);
    modport sink (input valid, moment_re, moment_im, point_x, point_y, sweep_end,
                  output ready);
endinterface

// File: rtl/hms_out_if.sv
interface hms_out_if import hms_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [MW-1:0] new_re;
    logic signed [MW-1:0] new_im;
    logic [6:0]           moment_index;
    logic                 point_done;
    logic [31:0]          next_step;
    logic                 step_ready;
    logic                 clipped;

    modport source (output valid, new_re, new_im, moment_index, point_done, next_step,
                    step_ready, clipped, input ready);
    modport sink (input valid, new_re, new_im, moment_index, point_done, next_step,
                  step_ready, clipped, output ready);
endinterface

// File: rtl/hms_mul.sv
module hms_mul import hms_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [63:0]        r_mag;
    logic [63:0]        r_b;
    logic               r_neg;
    logic               r_s28;
    logic               r_busy;
    logic               r_ppv;
    logic               r_done;
    logic [2:0]         r_cnt;
    logic [1:0]         r_sh;
    logic [63:0]        r_pp;
    logic [127:0]       r_acc;
    logic signed [63:0] r_res;

    logic [31:0]        w_ah;
    logic [31:0]        w_bh;
    logic [63:0]        w_prod;
    logic [127:0]       w_pp_sh;
    logic [127:0]       w_rsum;
    logic [127:0]       w_rsh;
    logic               w_cap;
    logic [63:0]        w_mag;
    logic [63:0]        w_amag;

    assign w_ah   = r_cnt[1] ? r_mag[63:32] : r_mag[31:0];
    assign w_bh   = r_cnt[0] ? r_b[63:32] : r_b[31:0];
    assign w_prod = w_ah * w_bh;
    assign w_amag = i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);

    always_comb begin
        case (r_sh)
            2'd0:    w_pp_sh = {64'd0, r_pp};
            2'd1:    w_pp_sh = {32'd0, r_pp, 32'd0};
            default: w_pp_sh = {r_pp, 64'd0};
        endcase
        w_rsum = r_acc + (r_s28 ? (128'd1 << (COEF_BITS - 1)) : (128'd1 << (PROD_SHIFT - 1)));
        w_rsh  = r_s28 ? (w_rsum >> COEF_BITS) : (w_rsum >> PROD_SHIFT);
        w_cap  = (|w_rsh[127:62]) || (w_rsh[61] && (|w_rsh[60:0]));
        w_mag  = w_cap ? (64'd1 << 61) : w_rsh[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 3'd5);
            if (i_req.start) begin
                r_mag  <= w_amag;
                r_neg  <= i_req.a[63];
                r_b    <= i_req.b;
                r_s28  <= i_req.s28;
                r_cnt  <= '0;
                r_busy <= 1'b1;
                r_ppv  <= 1'b0;
                if (i_req.clr) begin
                    r_acc <= '0;
                end
            end else if (r_busy) begin
                if (r_cnt < 3'd4) begin
                    r_pp <= w_prod;
                    r_sh <= 2'(r_cnt[1]) + 2'(r_cnt[0]);
                end
                r_ppv <= (r_cnt < 3'd4);
                if (r_ppv) begin
                    r_acc <= r_acc + w_pp_sh;
                end
                if (r_cnt == 3'd5) begin
                    r_res  <= r_neg ? -$signed(w_mag) : $signed(w_mag);
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
    assign o_rsp.acc  = r_acc;

endmodule

// File: rtl/hermite_moment_stencil_step_core.sv
// One explicit Hermite-moment timestep per Fourier point: moments 0..M stream in one at a
// time, each moment m is updated from its neighbors m-1 and m+1 and comes out when m+1 has
// arrived, and moment M follows unchanged as the point's last result. All products run on
// one shared 32x32 multiplier that builds each product from four partial products, so the
// block takes one item at a time: the item for moment 0 is only stored, every other item
// runs 17 products and a 33-step divide for the damping factor, the item of moment 0's
// update also computes the norm, the last item of a point also sends its pass-through
// result, and the last item of a sweep also runs the next step size search.
module hermite_moment_stencil_step_core import hms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    hms_in_if.sink               i_item,
    hms_out_if.source            o_result
);

    t_state             r_state;
    t_op                r_op;
    logic [6:0]         r_hm;
    logic [31:0]        r_step;
    logic [6:0]         r_cnt;
    logic [63:0]        r_max;
    logic [6:0]         r_m;
    logic               r_endpt;
    logic               r_last;
    logic [9:0]         r_kxy;
    logic signed [MW-1:0] r_g_re, r_g_im;
    logic signed [MW-1:0] r_old_re, r_old_im;
    logic signed [MW-1:0] r_mid_re, r_mid_im;
    logic [39:0]        r_w;
    logic [63:0]        r_x;
    logic [42:0]        r_num, r_den;
    logic [43:0]        r_rem;
    logic [33:0]        r_q;
    logic [5:0]         r_dcnt;
    logic [31:0]        r_damp;
    logic signed [63:0] r_t, r_are, r_aim, r_sre, r_sim;
    logic signed [MW-1:0] r_nre, r_nim;
    logic               r_clip;
    logic [4:0]         r_bit;
    logic [25:0]        r_d, r_tdt;

    logic               r_ovalid;
    logic signed [MW-1:0] r_o_re, r_o_im;
    logic [6:0]         r_o_idx;
    logic               r_o_done;
    logic [31:0]        r_o_next;
    logic               r_o_ready;
    logic               r_o_clip;

    t_mul_req           w_req;
    t_mul_rsp           w_rsp;
    logic [6:0]         w_m_eff;
    logic [31:0]        w_lo_c, w_up_c;
    logic [63:0]        w_nre_ext, w_nim_ext;
    logic [25:0]        n_tdt;
    logic [43:0]        n_rem_sh, n_rem;
    logic               n_ge;
    logic [33:0]        n_q;
    logic [31:0]        n_damp;
    logic [48:0]        n_sat;
    logic [63:0]        n_norm;
    logic               n_fits;

    localparam int NB = 64 + FRAC_BITS;

    function automatic logic [48:0] f_sat48(input logic signed [63:0] d);
        if (d[63:47] == {17{d[63]}}) begin
            return {1'b0, d[47:0]};
        end
        return {1'b1, d[63], {47{~d[63]}}};
    endfunction

    hms_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        if (r_hm == 7'd0) begin
            w_m_eff = 7'd1;
        end else if (32'(r_hm) > MAX_MOMENTS - 1) begin
            w_m_eff = 7'(MAX_MOMENTS - 1);
        end else begin
            w_m_eff = r_hm;
        end
    end

    assign w_lo_c    = COEF_TAB[CIW'(r_m) + CIW'(1)];
    assign w_up_c    = COEF_TAB[CIW'(r_m)];
    assign w_nre_ext = 64'(r_nre);
    assign w_nim_ext = 64'(r_nim);
    assign n_tdt     = r_d | (26'd1 << r_bit);
    assign n_rem_sh  = {r_rem[42:0], 1'b0};
    assign n_ge      = n_rem_sh >= {1'b0, r_den};
    assign n_rem     = n_ge ? n_rem_sh - {1'b0, r_den} : n_rem_sh;
    assign n_q       = {r_q[32:0], n_ge};
    assign n_damp    = 32'((35'(n_q) + 35'd1) >> 1);
    assign n_sat     = f_sat48(64'((r_op == OP_N1) ? r_mid_re : r_mid_im) - w_rsp.res);
    assign n_norm    = (|w_rsp.acc[127:FRAC_BITS+64]) ? '1 : w_rsp.acc[FRAC_BITS+63:FRAC_BITS];
    assign n_fits    = (w_rsp.acc[127:NB+1] == '0) && (!w_rsp.acc[NB] || w_rsp.acc[NB-1:0] == '0);

    always_comb begin
        w_req.start = (r_state == ST_ISSUE);
        w_req.clr   = 1'b1;
        w_req.s28   = 1'b0;
        w_req.a     = '0;
        w_req.b     = '0;
        case (r_op)
            OP_W:   begin w_req.a = 64'(r_kxy);   w_req.b = INV_TWO_PI_Q32; end
            OP_MM2: begin w_req.a = 64'(r_m);     w_req.b = 64'(r_m); end
            OP_MM3: begin w_req.a = r_x;          w_req.b = 64'(r_m); end
            OP_MM6: begin w_req.a = r_x;          w_req.b = r_x; end
            OP_MH2: begin w_req.a = 64'(w_m_eff); w_req.b = 64'(w_m_eff); end
            OP_MH3: begin w_req.a = r_x;          w_req.b = 64'(w_m_eff); end
            OP_MH6: begin w_req.a = r_x;          w_req.b = r_x; end
            OP_T1:  begin w_req.a = 64'(r_old_re); w_req.b = 64'(w_lo_c); w_req.s28 = 1'b1; end
            OP_T2:  begin w_req.a = 64'(r_g_re);   w_req.b = 64'(w_up_c); w_req.s28 = 1'b1; end
            OP_T3:  begin w_req.a = 64'(r_old_im); w_req.b = 64'(w_lo_c); w_req.s28 = 1'b1; end
            OP_T4:  begin w_req.a = 64'(r_g_im);   w_req.b = 64'(w_up_c); w_req.s28 = 1'b1; end
            OP_S1:  begin w_req.a = r_aim;         w_req.b = 64'(r_w); end
            OP_S2:  begin w_req.a = 64'(r_mid_re); w_req.b = 64'(r_damp); end
            OP_S3:  begin w_req.a = r_are;         w_req.b = 64'(r_w); end
            OP_S4:  begin w_req.a = 64'(r_mid_im); w_req.b = 64'(r_damp); end
            OP_N1:  begin w_req.a = r_sre;         w_req.b = 64'(r_step); end
            OP_N2:  begin w_req.a = r_sim;         w_req.b = 64'(r_step); end
            OP_Q1:  begin
                w_req.a = w_nre_ext;
                w_req.b = w_nre_ext[63] ? -w_nre_ext : w_nre_ext;
            end
            OP_Q2:  begin
                w_req.a   = w_nim_ext;
                w_req.b   = w_nim_ext[63] ? -w_nim_ext : w_nim_ext;
                w_req.clr = 1'b0;
            end
            OP_D1:  begin w_req.a = 64'(r_tdt); w_req.b = 64'(r_tdt); end
            OP_D2:  begin w_req.a = r_x;        w_req.b = r_max; end
            default: begin w_req.a = '0; w_req.b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_W;
            r_hm     <= HM_RESET;
            r_step   <= STEP_RESET;
            r_cnt    <= '0;
            r_max    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_item.valid) begin
                        r_g_re  <= i_item.moment_re;
                        r_g_im  <= i_item.moment_im;
                        r_last  <= i_item.sweep_end;
                        r_kxy   <= 10'(i_item.point_x % GRID_SIZE)
                                 + 10'(i_item.point_y % GRID_SIZE) + 10'd2;
                        r_endpt <= (r_cnt >= w_m_eff);
                        if (r_cnt == 7'd0) begin
                            r_old_re <= '0;
                            r_old_im <= MW'(INJECT_IM);
                            r_mid_re <= i_item.moment_re;
                            r_mid_im <= i_item.moment_im;
                            r_cnt    <= 7'd1;
                        end else begin
                            r_m     <= r_cnt - 7'd1;
                            r_op    <= OP_W;
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_rsp.done) begin
                        r_op <= t_op'(r_op + 5'd1);
                        case (r_op)
                            OP_W: begin
                                r_w     <= w_rsp.acc[39:0];
                                r_state <= ST_ISSUE;
                            end
                            OP_MM2, OP_MM3, OP_MH2, OP_MH3: begin
                                r_x     <= w_rsp.acc[63:0];
                                r_state <= ST_ISSUE;
                            end
                            OP_MM6: begin
                                r_num   <= w_rsp.acc[42:0];
                                r_state <= ST_ISSUE;
                            end
                            OP_MH6: begin
                                r_den   <= w_rsp.acc[42:0];
                                r_rem   <= {1'b0, r_num};
                                r_q     <= '0;
                                r_dcnt  <= '0;
                                r_state <= ST_DIV;
                            end
                            OP_T1, OP_T3, OP_S3: begin
                                r_t     <= w_rsp.res;
                                r_state <= ST_ISSUE;
                            end
                            OP_S1: begin
                                r_t     <= -w_rsp.res;
                                r_state <= ST_ISSUE;
                            end
                            OP_T2: begin
                                r_are   <= r_t + w_rsp.res;
                                r_state <= ST_ISSUE;
                            end
                            OP_T4: begin
                                r_aim   <= r_t + w_rsp.res;
                                r_state <= ST_ISSUE;
                            end
                            OP_S2: begin
                                r_sre   <= r_t + w_rsp.res;
                                r_state <= ST_ISSUE;
                            end
                            OP_S4: begin
                                r_sim   <= r_t + w_rsp.res;
                                r_state <= ST_ISSUE;
                            end
                            OP_N1: begin
                                r_nre   <= n_sat[47:0];
                                r_clip  <= n_sat[48];
                                r_state <= ST_ISSUE;
                            end
                            OP_N2: begin
                                r_nim   <= n_sat[47:0];
                                r_clip  <= r_clip | n_sat[48];
                                r_state <= (r_m != 7'd0) ? ST_FIN : ST_ISSUE;
                            end
                            OP_Q2: begin
                                if (n_norm > r_max) begin
                                    r_max <= n_norm;
                                end
                                r_state <= ST_FIN;
                            end
                            OP_D1: begin
                                r_x     <= w_rsp.acc[63:0];
                                r_state <= ST_ISSUE;
                            end
                            OP_D2: begin
                                if (n_fits) begin
                                    r_d <= r_tdt;
                                end
                                if (r_bit == 5'd0) begin
                                    r_state <= ST_FIN2;
                                end else begin
                                    r_bit   <= r_bit - 5'd1;
                                    r_state <= ST_DTSEL;
                                end
                            end
                            default: r_state <= ST_ISSUE;
                        endcase
                    end
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_q    <= n_q;
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd32) begin
                        r_damp  <= (r_m < w_m_eff) ? n_damp : '0;
                        r_op    <= OP_T1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_FIN: begin
                    r_old_re  <= r_mid_re;
                    r_old_im  <= r_mid_im;
                    r_mid_re  <= r_g_re;
                    r_mid_im  <= r_g_im;
                    r_o_re    <= r_nre;
                    r_o_im    <= r_nim;
                    r_o_idx   <= r_m;
                    r_o_done  <= 1'b0;
                    r_o_next  <= '0;
                    r_o_ready <= 1'b0;
                    r_o_clip  <= r_clip;
                    r_ovalid  <= 1'b1;
                    r_state   <= ST_OUT1;
                end
                ST_OUT1: begin
                    if (o_result.ready) begin
                        r_ovalid <= 1'b0;
                        if (!r_endpt) begin
                            r_cnt   <= r_cnt + 7'd1;
                            r_state <= ST_IDLE;
                        end else if (r_last) begin
                            r_bit   <= 5'd25;
                            r_d     <= '0;
                            r_state <= ST_DTSEL;
                        end else begin
                            r_state <= ST_FIN2;
                        end
                    end
                end
                ST_DTSEL: begin
                    if (n_tdt > DT_CAP) begin
                        if (r_bit == 5'd0) begin
                            r_state <= ST_FIN2;
                        end else begin
                            r_bit <= r_bit - 5'd1;
                        end
                    end else begin
                        r_tdt   <= n_tdt;
                        r_op    <= OP_D1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_FIN2: begin
                    r_o_re    <= r_g_re;
                    r_o_im    <= r_g_im;
                    r_o_idx   <= w_m_eff;
                    r_o_done  <= 1'b1;
                    r_o_next  <= r_last ? 32'(r_d) : '0;
                    r_o_ready <= r_last;
                    r_o_clip  <= 1'b0;
                    r_ovalid  <= 1'b1;
                    r_cnt     <= '0;
                    if (r_last) begin
                        r_max <= '0;
                    end
                    r_state <= ST_OUT2;
                end
                ST_OUT2: begin
                    if (o_result.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HIGHEST_MOMENT: begin
                        r_hm  <= i_cfg_data[6:0];
                        r_cnt <= '0;
                    end
                    CFG_STEP_SIZE: r_step <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign i_item.ready          = (r_state == ST_IDLE);
    assign o_result.valid        = r_ovalid;
    assign o_result.new_re       = r_o_re;
    assign o_result.new_im       = r_o_im;
    assign o_result.moment_index = r_o_idx;
    assign o_result.point_done   = r_o_done;
    assign o_result.next_step    = r_o_next;
    assign o_result.step_ready   = r_o_ready;
    assign o_result.clipped      = r_o_clip;

endmodule

// File: rtl/hms_checker.sv
module hms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_point_done,
    input logic        i_step_ready,
    input logic        i_clipped,
    input logic [31:0] i_next_step
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while a result is pending");

    a_ready_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_step_ready |-> i_point_done)
        else $error("step ready outside the last result of a point");

    a_next_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_step_ready |-> i_next_step == 32'd0)
        else $error("next step nonzero without step ready");

    a_pass_unclipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_point_done |-> !i_clipped)
        else $error("pass-through result flagged as clipped");

endmodule

bind hermite_moment_stencil_step_core hms_checker u_hms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_point_done (o_result.point_done),
    .i_step_ready (o_result.step_ready),
    .i_clipped    (o_result.clipped),
    .i_next_step  (o_result.next_step)
);

// File: tb/tb_hermite_moment_stencil_step_core.sv
`timescale 1ns / 100ps

module tb_hermite_moment_stencil_step_core;
    import hms_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 20000;
    localparam int                   SETTLE_CYCLES  = 1200;
    localparam int                   HOLD_CYCLES    = 3000;
    localparam int                   ITEM_TARGET    = 1950;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd2;
    localparam logic [31:0]          COEF_ROOT_SHIFT = 2 * COEF_BITS - 1;
    localparam logic signed [63:0]   SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0]   SAT_LO = -64'sh0000_8000_0000_0000;

    typedef struct {
        logic [47:0] re;
        logic [47:0] im;
        logic [7:0]  px;
        logic [7:0]  py;
        logic        last;
    } moment_item_t;

    typedef struct {
        logic [47:0] re;
        logic [47:0] im;
        logic [6:0]  idx;
        logic        done;
        logic [31:0] nxt;
        logic        ready;
        logic        clip;
    } moment_result_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;

    hms_in_if  itf_in ();
    hms_out_if itf_out ();

    hermite_moment_stencil_step_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (itf_in),
        .o_result   (itf_out)
    );

    moment_item_t   pending_items[$];
    moment_result_t expected_moments[$];

    // Predictor state.
    logic [6:0]         hm_reg;
    logic [31:0]        dt_reg;
    logic signed [63:0] win_old_re, win_old_im, win_mid_re, win_mid_im;
    int unsigned        next_moment;
    logic [63:0]        peak_norm;
    logic [31:0]        damp_tab [0:MAX_MOMENTS-1];

    int  in_count, out_count, sweep_count, phase_count, mismatches, idle_cycles, gap_left;
    int  hold_left, stall_left;
    bit  pressure_done;
    bit  no_idle;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int unsigned top_moment(logic [6:0] hm);
        if (hm < 1) return 1;
        return hm;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v_in);
        logic [63:0] v, r, b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] scale_round(logic signed [63:0] a, logic [63:0] b,
                                                        int s);
        logic [63:0]  mag, r;
        logic [127:0] p;
        mag = a[63] ? (~a + 64'd1) : a;
        p = (128'(mag) * 128'(b) + (128'd1 << (s - 1))) >> s;
        r = (p > (128'd1 << 61)) ? (64'd1 << 61) : p[63:0];
        return a[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] clamp48(logic signed [63:0] x, ref bit clip);
        if (x > SAT_HI) begin
            clip = 1'b1;
            return SAT_HI;
        end
        if (x < SAT_LO) begin
            clip = 1'b1;
            return SAT_LO;
        end
        return x;
    endfunction

    function automatic logic [63:0] power_norm(logic signed [63:0] re, logic signed [63:0] im);
        logic [63:0]  a, b;
        logic [127:0] s;
        a = re[63] ? (~re + 64'd1) : re;
        b = im[63] ? (~im + 64'd1) : im;
        s = (128'(a) * 128'(a) + 128'(b) * 128'(b)) >> FRAC_BITS;
        return (s[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [31:0] step_from_norm(logic [63:0] n);
        logic [63:0]  d, t;
        logic [127:0] p;
        d = '0;
        for (int b = 25; b >= 0; b--) begin
            t = d | (64'd1 << b);
            if (t <= 64'(DT_CAP)) begin
                p = 128'(t * t) * 128'(n);
                if (p <= (128'd1 << (64 + FRAC_BITS))) d = t;
            end
        end
        return d[31:0];
    endfunction

    task automatic enqueue_item(moment_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic rebuild_damping();
        logic [63:0] den, rem, q;
        int unsigned mm;
        mm = top_moment(hm_reg);
        den = 64'(mm) ** 6;
        for (int m = 0; m < MAX_MOMENTS; m++) begin
            damp_tab[m] = '0;
            if (m < mm) begin
                rem = 64'(m) ** 6;
                q = '0;
                for (int i = 0; i < 33; i++) begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= den) begin
                        rem = rem - den;
                        q[0] = 1'b1;
                    end
                end
                damp_tab[m] = 32'((q + 64'd1) >> 1);
            end
        end
    endtask

    task automatic predict_moment(moment_item_t it);
        logic signed [63:0] g_re, g_im, a_re, a_im, s_re, s_im, n_re, n_im;
        logic [63:0]        w, lo_c, up_c, damp;
        int unsigned        mm, c, m;
        bit                 clip;
        moment_result_t     r;
        g_re = 64'(signed'(it.re));
        g_im = 64'(signed'(it.im));
        mm = top_moment(hm_reg);
        c = next_moment;
        clip = 1'b0;
        if (c == 0) begin
            win_old_re = '0;
            win_old_im = $signed(INJECT_IM);
            win_mid_re = g_re;
            win_mid_im = g_im;
            next_moment = 1;
            return;
        end
        m = c - 1;
        w = (64'(it.px) + 64'(it.py) + 64'd2) * INV_TWO_PI_Q32;
        lo_c = root64(64'(m + 1) << COEF_ROOT_SHIFT);
        up_c = root64(64'(m) << COEF_ROOT_SHIFT);
        damp = 64'(damp_tab[m % MAX_MOMENTS]);
        a_re = scale_round(win_old_re, lo_c, COEF_BITS) + scale_round(g_re, up_c, COEF_BITS);
        a_im = scale_round(win_old_im, lo_c, COEF_BITS) + scale_round(g_im, up_c, COEF_BITS);
        s_re = -scale_round(a_im, w, 32) + scale_round(win_mid_re, damp, 32);
        s_im = scale_round(a_re, w, 32) + scale_round(win_mid_im, damp, 32);
        n_re = clamp48(win_mid_re - scale_round(s_re, 64'(dt_reg), 32), clip);
        n_im = clamp48(win_mid_im - scale_round(s_im, 64'(dt_reg), 32), clip);
        r = '{re: n_re[47:0], im: n_im[47:0], idx: 7'(m), done: 1'b0, nxt: '0,
              ready: 1'b0, clip: clip};
        expected_moments = {expected_moments, r};
        if (m == 0) begin
            if (power_norm(n_re, n_im) > peak_norm) peak_norm = power_norm(n_re, n_im);
        end
        win_old_re = win_mid_re;
        win_old_im = win_mid_im;
        win_mid_re = g_re;
        win_mid_im = g_im;
        if (c >= mm) begin
            r = '{re: it.re, im: it.im, idx: 7'(mm), done: 1'b1,
                  nxt: it.last ? step_from_norm(peak_norm) : 32'd0, ready: it.last, clip: 1'b0};
            expected_moments = {expected_moments, r};
            next_moment = 0;
            if (it.last) peak_norm = '0;
        end else begin
            next_moment = c + 1;
        end
    endtask

    function automatic logic [47:0] pick_moment();
        int kind;
        kind = $urandom_range(0, 11);
        case (kind)
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return '0;
            3: return 48'({$urandom, $urandom});
            4, 5: return 48'(signed'(17'(signed'($urandom_range(0, 131071) - 65536))));
            default: return 48'(signed'(41'({$urandom, $urandom})));
        endcase
    endfunction

    task automatic queue_point(int unsigned mm, bit last, bit tiny);
        moment_item_t it;
        bit           noisy;
        noisy = ($urandom_range(0, 9) == 0);
        it.px = 8'($urandom_range(0, 255));
        it.py = 8'($urandom_range(0, 255));
        for (int unsigned k = 0; k <= mm; k++) begin
            it.re = tiny ? 48'(signed'(16'($urandom))) : pick_moment();
            it.im = tiny ? 48'(signed'(16'($urandom))) : pick_moment();
            it.last = last;
            if (noisy) begin
                it.px = 8'($urandom_range(0, 255));
                it.py = 8'($urandom_range(0, 255));
                if (k != mm) it.last = 1'($urandom_range(0, 1));
            end
            enqueue_item(it);
        end
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || expected_moments.size() != 0 || itf_in.valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_HIGHEST_MOMENT) begin
            hm_reg = data[6:0];
            next_moment = 0;
            rebuild_damping();
        end else if (idx == CFG_STEP_SIZE) begin
            dt_reg = data;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Input driver and input-side prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            itf_in.valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (itf_in.valid && itf_in.ready) begin
                predict_moment('{re: itf_in.moment_re, im: itf_in.moment_im,
                                 px: itf_in.point_x, py: itf_in.point_y,
                                 last: itf_in.sweep_end});
                in_count++;
                idle_cycles = 0;
                if ($urandom_range(0, 149) == 0) no_idle <= ~no_idle;
            end
            if (!itf_in.valid || itf_in.ready) begin
                if (gap_left > 0 && !no_idle) begin
                    gap_left <= gap_left - 1;
                    itf_in.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    moment_item_t it;
                    it = pending_items.pop_front();
                    itf_in.valid     <= 1'b1;
                    itf_in.moment_re <= it.re;
                    itf_in.moment_im <= it.im;
                    itf_in.point_x   <= it.px;
                    itf_in.point_y   <= it.py;
                    itf_in.sweep_end <= it.last;
                    if ($urandom_range(0, 19) == 0) gap_left <= $urandom_range(20, 400);
                    else if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
                    else gap_left <= 0;
                end else begin
                    itf_in.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver with random stalls and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            itf_out.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            itf_out.ready <= 1'b0;
        end else if (!pressure_done && in_count >= 400) begin
            pressure_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            itf_out.ready <= 1'b0;
        end else if (stall_left > 0 && !no_idle) begin
            stall_left <= stall_left - 1;
            itf_out.ready <= 1'b0;
        end else if (no_idle) begin
            itf_out.ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_left <= $urandom_range(50, 600);
            itf_out.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && itf_out.valid && itf_out.ready) begin
            moment_result_t want;
            idle_cycles = 0;
            out_count++;
            if (itf_out.step_ready) sweep_count++;
            if (expected_moments.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: idx %0d re %h im %h",
                             itf_out.moment_index, itf_out.new_re, itf_out.new_im);
            end else begin
                want = expected_moments.pop_front();
                if (itf_out.new_re !== want.re || itf_out.new_im !== want.im ||
                    itf_out.moment_index !== want.idx || itf_out.point_done !== want.done ||
                    itf_out.next_step !== want.nxt || itf_out.step_ready !== want.ready ||
                    itf_out.clipped !== want.clip) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch exp: re %h im %h idx %0d done %b nxt %h rdy %b clip %b",
                                 want.re, want.im, want.idx, want.done, want.nxt, want.ready,
                                 want.clip);
                        $display("         got: re %h im %h idx %0d done %b nxt %h rdy %b clip %b",
                                 itf_out.new_re, itf_out.new_im, itf_out.moment_index,
                                 itf_out.point_done, itf_out.next_step, itf_out.step_ready,
                                 itf_out.clipped);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", expected_moments.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int unsigned mm;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        itf_in.valid = 1'b0;
        itf_in.moment_re = '0;
        itf_in.moment_im = '0;
        itf_in.point_x = '0;
        itf_in.point_y = '0;
        itf_in.sweep_end = 1'b0;
        itf_out.ready = 1'b0;
        hm_reg = HM_RESET;
        dt_reg = STEP_RESET;
        win_old_re = '0;
        win_old_im = '0;
        win_mid_re = '0;
        win_mid_im = '0;
        next_moment = 0;
        peak_norm = '0;
        rebuild_damping();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults from reset: one full-length point that ends a sweep.
        queue_point(top_moment(hm_reg), 1'b1, 1'b0);
        settle();
        phase_count++;

        // Directed: shortest points, full-scale step, extreme moments and indices.
        write_reg(CFG_HIGHEST_MOMENT, 32'd1);
        write_reg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
        enqueue_item(moment_item_t'{48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 8'd255, 8'd255, 1'b0});
        enqueue_item(moment_item_t'{48'h8000_0000_0000, 48'h8000_0000_0000, 8'd255, 8'd255, 1'b0});
        enqueue_item(moment_item_t'{48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 8'd0, 8'd0, 1'b1});
        enqueue_item(moment_item_t'{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 8'd0, 8'd0, 1'b1});
        enqueue_item(moment_item_t'{48'h0, 48'h0, 8'd0, 8'd255, 1'b0});
        enqueue_item(moment_item_t'{48'h0, 48'h0, 8'd255, 8'd0, 1'b1});
        settle();
        // A tiny step with tiny moments gives a zero peak norm at the sweep's end.
        write_reg(CFG_HIGHEST_MOMENT, 32'd2);
        write_reg(CFG_STEP_SIZE, 32'd1);
        enqueue_item(moment_item_t'{48'h0, 48'h0, 8'd0, 8'd0, 1'b1});
        enqueue_item(moment_item_t'{48'h1, 48'hFFFF_FFFF_FFFF, 8'd0, 8'd0, 1'b1});
        enqueue_item(moment_item_t'{48'h0, 48'h0, 8'd0, 8'd0, 1'b1});
        settle();
        // Out-of-range M clamps to one; a write to an unused index is ignored.
        write_reg(CFG_HIGHEST_MOMENT, 32'd0);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        queue_point(1, 1'b0, 1'b0);
        queue_point(1, 1'b1, 1'b0);
        settle();
        write_reg(CFG_HIGHEST_MOMENT, 32'd127);
        write_reg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
        queue_point(127, 1'b1, 1'b0);
        settle();
        phase_count += 4;

        while (in_count < ITEM_TARGET) begin
            write_reg(CFG_HIGHEST_MOMENT, ($urandom_range(0, 7) == 0) ? 32'hFFFF_FF80 +
                      $urandom_range(0, 127) : 32'($urandom_range(1, 12)));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
                1: write_reg(CFG_STEP_SIZE, $urandom_range(1, 100000));
                default: write_reg(CFG_STEP_SIZE, $urandom);
            endcase
            mm = top_moment(hm_reg);
            for (int p = 0; p < 8 && (mm <= 12 || p < 1); p++)
                queue_point(mm, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
            settle();
            phase_count++;
        end

        settle();
        $display("Run covered %0d phases: %0d moments in, %0d results out, %0d sweep ends.",
                 phase_count, in_count, out_count, sweep_count);
        if (mismatches == 0 && expected_moments.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
